// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; both expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define GPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GPS_ASSERT_IMP(label, ante, cons)
`define GPS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/gps_pkg.sv =====
// ----------------------------------------------------------------------------
// gps_pkg
// Shared constants and types of the gamepad poll scanner.
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int READS_PER_POLL = 8;
  localparam int PAD_COUNT      = 2;
  localparam int CNT_W          = $clog2(READS_PER_POLL);

  localparam int DATA_W   = 16;
  localparam int OFF_W    = 4;
  localparam int FIELD_W  = 6;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 64;

  localparam int CONN_BIT = 56;
  localparam int SIX_BIT  = 8;

  localparam int KEY_COUNT = 12;
  localparam int BASE_KEYS = 8;

  // event slots per pad: connection, twelve keys, sync
  localparam int EV_COUNT = KEY_COUNT + 2;
  localparam int POS_W    = $clog2(EV_COUNT);
  localparam logic [POS_W-1:0] EV_CONN = POS_W'(0);
  localparam logic [POS_W-1:0] EV_SYNC = POS_W'(EV_COUNT - 1);

  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_CONN = 2'd1;
  localparam logic [1:0] KIND_SYNC = 2'd2;

  localparam logic REG_LEFT_OFFSET  = 1'b0;
  localparam logic REG_RIGHT_OFFSET = 1'b1;

  localparam logic [OFF_W-1:0] LEFT_OFFSET_RESET  = OFF_W'(0);
  localparam logic [OFF_W-1:0] RIGHT_OFFSET_RESET = OFF_W'(8);

  // bit of the poll word for each key code
  localparam logic [5:0] KEY_BIT [KEY_COUNT] = '{
    6'd59, 6'd58, 6'd48, 6'd49, 6'd60, 6'd52,
    6'd53, 6'd61, 6'd18, 6'd19, 6'd20, 6'd16
  };

  localparam int FIFO_DEPTH = 2;

  typedef logic [PAD_COUNT-1:0][EV_COUNT-1:0] ev_vec_t;

  typedef struct packed {
    ev_vec_t mask;
    ev_vec_t level;
  } job_t;

  typedef struct packed {
    logic       level;
    logic [3:0] key_code;
    logic [1:0] event_kind;
    logic       pad_index;
  } result_t;

endpackage

// ===== rtl/gps_front.sv =====
// ----------------------------------------------------------------------------
// gps_front
// Accepts bus reads, builds the poll words and turns a closed poll into a job.
// ----------------------------------------------------------------------------
module gps_front import gps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic              s_tuser,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [OFF_W-1:0]  cfg_data,
  output logic              push,
  output job_t              job,
  input  logic              full
);

  logic [OFF_W-1:0]  offset      [PAD_COUNT];
  logic [CNT_W-1:0]  read_count;
  logic [WORD_W-1:0] shift_word  [PAD_COUNT];
  logic [WORD_W-1:0] prev_word   [PAD_COUNT];
  logic [PAD_COUNT-1:0] seen_once;

  logic [WORD_W-1:0] shift_next  [PAD_COUNT];
  logic              accept;
  logic              closing;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign closing  = (read_count == CNT_W'(READS_PER_POLL - 1));
  assign push     = accept && !s_tuser && closing && (|seen_once);

  always_comb begin
    logic [DATA_W-1:0] sh;
    for (int p = 0; p < PAD_COUNT; p++) begin
      sh = s_tdata >> offset[p];
      shift_next[p] = {shift_word[p][WORD_W-BYTE_W-1:0],
                       BYTE_W'(sh[FIELD_W-1:0])};
    end
  end

  // change mask and new levels for each event slot
  always_comb begin
    logic [WORD_W-1:0] ch;
    logic              six;
    job = '0;
    for (int p = 0; p < PAD_COUNT; p++) begin
      ch  = shift_next[p] ^ prev_word[p];
      six = shift_next[p][SIX_BIT];
      job.mask[p][EV_CONN]  = ch[CONN_BIT] && seen_once[p];
      job.level[p][EV_CONN] = !shift_next[p][CONN_BIT];
      for (int k = 0; k < KEY_COUNT; k++) begin
        job.mask[p][k+1]  = ch[KEY_BIT[k]] && seen_once[p] && ((k < BASE_KEYS) || six);
        job.level[p][k+1] = !shift_next[p][KEY_BIT[k]];
      end
      job.mask[p][EV_SYNC]  = seen_once[p];
      job.level[p][EV_SYNC] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset[0]  <= LEFT_OFFSET_RESET;
      offset[1]  <= RIGHT_OFFSET_RESET;
      read_count <= '0;
      seen_once  <= '0;
      for (int p = 0; p < PAD_COUNT; p++) shift_word[p] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_OFFSET:  offset[0] <= cfg_data;
          REG_RIGHT_OFFSET: offset[1] <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (s_tuser || closing) begin
          read_count <= '0;
          for (int p = 0; p < PAD_COUNT; p++) shift_word[p] <= '0;
          if (!s_tuser) seen_once <= '1;
        end else begin
          read_count <= read_count + CNT_W'(1);
          for (int p = 0; p < PAD_COUNT; p++) shift_word[p] <= shift_next[p];
        end
      end
    end
  end

  // previous poll word, valid once seen_once is set
  always_ff @(posedge clk) begin
    if (accept && !s_tuser && closing) begin
      for (int p = 0; p < PAD_COUNT; p++) prev_word[p] <= shift_next[p];
    end
  end

endmodule

// ===== rtl/gps_fifo.sv =====
// ----------------------------------------------------------------------------
// gps_fifo
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module gps_fifo import gps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  job_t                mem [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W:0]      count;

  assign full  = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + (PTR_W+1)'(1);
      else if (pop && !push) count <= count - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

// ===== rtl/gps_back.sv =====
// ----------------------------------------------------------------------------
// gps_back
// Walks a job's pending events to the output, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gps_back import gps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       job,
  input  logic       empty,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output result_t    m_tdata,
  output logic       m_tlast
);

  ev_vec_t          mask;
  ev_vec_t          level;
  logic             busy;
  logic             step;
  logic             cur;
  logic [POS_W-1:0] pos;
  logic             later;
  logic             sel_last;
  result_t          res;

  assign busy = |mask;
  assign step = busy && (!m_tvalid || m_tready);
  assign pop  = !busy && !empty;

  always_comb begin
    logic [EV_COUNT-1:0] rest;
    cur = 1'b0;
    for (int p = PAD_COUNT - 1; p >= 0; p--) begin
      if (|mask[p]) cur = 1'(p);
    end
    pos = '0;
    for (int i = EV_COUNT - 1; i >= 0; i--) begin
      if (mask[cur][i]) pos = POS_W'(i);
    end
    later = 1'b0;
    for (int p = 0; p < PAD_COUNT; p++) begin
      if (p > int'(cur) && (|mask[p])) later = 1'b1;
    end
    rest = mask[cur];
    rest[pos] = 1'b0;
    sel_last = (rest == '0) && !later;

    res.pad_index = cur;
    if (pos == EV_CONN) begin
      res.event_kind = KIND_CONN;
      res.key_code   = 4'd0;
      res.level      = level[cur][pos];
    end else if (pos == EV_SYNC) begin
      res.event_kind = KIND_SYNC;
      res.key_code   = 4'd0;
      res.level      = 1'b0;
    end else begin
      res.event_kind = KIND_KEY;
      res.key_code   = 4'(pos - POS_W'(1));
      res.level      = level[cur][pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        mask <= job.mask;
      end else if (step) begin
        mask[cur][pos] <= 1'b0;
      end
      if (step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) level <= job.level;
    if (step) begin
      m_tdata <= res;
      m_tlast <= sel_last;
    end
  end

  // the final event of a job leaves nothing pending
  `GPS_ASSERT_NXT(a_last_drains, step && sel_last, !busy)
  // every queued job carries at least one sync event
  `GPS_ASSERT_NXT(a_job_nonempty, pop, busy)
  // a run always closes with a sync event
  `GPS_ASSERT_IMP(a_last_is_sync, m_tvalid && m_tlast, m_tdata.event_kind == KIND_SYNC)

endmodule

// ===== rtl/gamepad_poll_scanner_core.sv =====
// ----------------------------------------------------------------------------
// gamepad_poll_scanner_core
// Two-pad polled controller scanner producing key, connection and sync events.
// ----------------------------------------------------------------------------
// Each bus read (one transaction on the slave side) enters the front end,
// which can accept a read every cycle; reads stall only while the queue holds
// two unfinished jobs. For each pad it pulls a 6-bit field at that pad's
// offset and shifts it into a 64-bit poll word; the eighth good read closes
// the poll. A closing read compares each pad's word with the previous one and
// pushes one job (per-pad change mask plus new levels) into a two-entry
// queue. The back end drains a job at one event per cycle while m_tready
// allows: a connection change, key changes in fixed key order (twelve keys
// when bit 8 marks a six-button pad, else eight) and a sync per pad, so a
// poll yields 2 to 28 events. The first poll after reset emits nothing. A
// read flagged as failed in tuser clears the read counter and both poll words
// without output. tlast marks the last event of a poll. Offsets must be
// written on the cfg port while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module gamepad_poll_scanner_core import gps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // bus reads
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [15:0] read_data
  input  logic              s_tuser,   // [0] read_failed
  // events
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [0] pad_index, [2:1] event_kind,
                                       // [6:3] key_code, [7] level
  output logic              m_tlast,   // last_of_run
  // configuration: index 0 left offset, 1 right offset
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [OFF_W-1:0]  cfg_data
);

  logic    push;
  logic    full;
  logic    pop;
  logic    empty;
  job_t    job_in;
  job_t    job_out;
  result_t res;

  gps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .job       (job_in),
    .full      (full)
  );

  // decouples poll closing from event drain
  gps_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .full  (full),
    .pop   (pop),
    .dout  (job_out),
    .empty (empty)
  );

  gps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (job_out),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (res),
    .m_tlast  (m_tlast)
  );

  assign m_tdata = res;

endmodule
